@@ sv/fraction_arithmetic_unit_assert.svh @@
// Assertion macros for the fraction arithmetic unit datapath.
`ifndef FRACTION_ARITHMETIC_UNIT_ASSERT_SVH
`define FRACTION_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define FAU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fraction arithmetic unit: assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define FAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fraction arithmetic unit: assertion failed");

`endif

@@ sv/fau_pkg.sv @@
// Package with the shared types and constants of the fraction arithmetic unit.
`default_nettype none

package fau_pkg;

	// Default operand width and the fixed widths of the result fields.
	localparam int DEF_OPERAND_WIDTH = 16;
	localparam int NUM_OUT_W         = 33;
	localparam int DEN_OUT_W         = 32;

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_CHECK,
		ST_GCD,
		ST_DIVN,
		ST_NSTORE,
		ST_DIVD,
		ST_DSTORE,
		ST_DONE
	} fsm_state_t;

	// Datapath commands, one per cycle.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL0,
		CMD_MUL1,
		CMD_MUL2,
		CMD_MUL3,
		CMD_CHECK,
		CMD_GCD_STEP,
		CMD_GCD_FINISH,
		CMD_DIV_STEP,
		CMD_NUM_STORE,
		CMD_DEN_STORE,
		CMD_OUT_LOAD
	} dp_cmd_t;

	// Controller to datapath.
	typedef struct packed {
		dp_cmd_t cmd;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic       den_zero;
		logic       gcd_done;
		logic       div_last;
		logic       out_busy;
	} stat_t;

endpackage

`default_nettype wire

@@ sv/fau_ctrl.sv @@
// Controller state machine that sequences the fraction arithmetic datapath.
`default_nettype none

module fau_ctrl
	import fau_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  stat_t      stat,
	output ctl_t       ctl
);

	fsm_state_t state_q;
	fsm_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL0;
			end
			ST_MUL0:   state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = stat.den_zero ? ST_DONE : ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) state_d = ST_DIVN;
			end
			ST_DIVN: begin
				if (stat.div_last) state_d = ST_NSTORE;
			end
			ST_NSTORE: state_d = ST_DIVD;
			ST_DIVD: begin
				if (stat.div_last) state_d = ST_DSTORE;
			end
			ST_DSTORE: state_d = ST_DONE;
			ST_DONE: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: datapath command and input stall.
	always_comb begin
		ctl.cmd  = CMD_NONE;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:   ctl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
			ST_MUL0:   ctl.cmd = CMD_MUL0;
			ST_MUL1:   ctl.cmd = CMD_MUL1;
			ST_MUL2:   ctl.cmd = CMD_MUL2;
			ST_MUL3:   ctl.cmd = CMD_MUL3;
			ST_CHECK:  ctl.cmd = CMD_CHECK;
			ST_GCD:    ctl.cmd = stat.gcd_done ? CMD_GCD_FINISH : CMD_GCD_STEP;
			ST_DIVN:   ctl.cmd = CMD_DIV_STEP;
			ST_NSTORE: ctl.cmd = CMD_NUM_STORE;
			ST_DIVD:   ctl.cmd = CMD_DIV_STEP;
			ST_DSTORE: ctl.cmd = CMD_DEN_STORE;
			ST_DONE:   ctl.cmd = stat.out_busy ? CMD_NONE : CMD_OUT_LOAD;
			default:   ctl.cmd = CMD_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/fau_datapath.sv @@
// Datapath: shared multiplier, binary GCD unit, restoring divider and output register.
`default_nettype none
`include "fraction_arithmetic_unit_assert.svh"

module fau_datapath
	import fau_pkg::*;
#(
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  op,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
	input  ctl_t                             ctl,
	output stat_t                            stat,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic signed [NUM_OUT_W-1:0]      res_num,
	output logic signed [DEN_OUT_W-1:0]      res_den,
	output logic                             zero_den
);

	localparam int W  = OPERAND_WIDTH;
	// Internal word: exact sum of two products, capped at a 64-bit wrapping word.
	localparam int NW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
	localparam int CW = $clog2(NW);

	// Latched transaction operands.
	logic [1:0]          op_q;
	logic signed [W-1:0] an_q;
	logic signed [W-1:0] ad_q;
	logic signed [W-1:0] bn_q;
	logic signed [W-1:0] bd_q;

	// Multiplier.
	logic signed [W-1:0]   mul_x;
	logic signed [W-1:0]   mul_y;
	logic signed [2*W-1:0] prod_s1;
	logic [NW-1:0]         prod_ext;

	// Raw result, GCD and divider state.
	logic [NW-1:0] num_q;
	logic [NW-1:0] den_q;
	logic [NW-1:0] num_mag;
	logic [NW-1:0] den_mag;
	logic [NW-1:0] u_q;
	logic [NW-1:0] v_q;
	logic [CW-1:0] k_q;
	logic [NW-1:0] g_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   div_shift;
	logic [NW:0]   div_trial;

	// Final values before the output register.
	logic [NW-1:0]        fn_q;
	logic [NW-1:0]        fd_q;
	logic                 flag_q;
	logic signed [63:0]   fn_ext;
	logic signed [63:0]   fd_ext;
	logic                 out_valid_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctl.cmd)
			CMD_MUL0: begin
				mul_x = an_q;
				mul_y = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			CMD_MUL1: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			CMD_MUL2: begin
				mul_x = ad_q;
				mul_y = (op_q == OP_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_x = an_q;
				mul_y = bd_q;
			end
		endcase
	end

	// Sign extension, magnitudes and one divider step.
	assign prod_ext  = NW'(prod_s1);
	assign num_mag   = num_q[NW-1] ? (NW'(0) - num_q) : num_q;
	assign den_mag   = den_q[NW-1] ? (NW'(0) - den_q) : den_q;
	assign div_shift = {rem_q, quo_q[NW-1]};
	assign div_trial = div_shift - {1'b0, g_q};

	// Status toward the controller.
	assign stat.den_zero = (den_q == '0);
	assign stat.gcd_done = (u_q == '0);
	assign stat.div_last = (cnt_q == CW'(NW - 1));
	assign stat.out_busy = out_valid_q && out_stall;

	// Control registers: output valid and iteration counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
		end else begin
			if (ctl.cmd == CMD_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			priority case (ctl.cmd)
				CMD_CHECK:      k_q <= '0;
				CMD_GCD_STEP: begin
					if (!u_q[0] && !v_q[0]) k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
			priority case (ctl.cmd)
				CMD_GCD_FINISH, CMD_NUM_STORE: cnt_q <= '0;
				CMD_DIV_STEP:                  cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_x * mul_y;
		unique case (ctl.cmd)
			CMD_LOAD: begin
				op_q <= op;
				an_q <= a_num;
				ad_q <= a_den;
				bn_q <= b_num;
				bd_q <= b_den;
			end
			CMD_MUL1: begin
				num_q <= prod_ext;
			end
			CMD_MUL2: begin
				// Cross term only for addition and subtraction.
				if (op_q == OP_ADD) begin
					num_q <= num_q + prod_ext;
				end else if (op_q == OP_SUB) begin
					num_q <= num_q - prod_ext;
				end
			end
			CMD_MUL3: begin
				den_q <= prod_ext;
			end
			CMD_CHECK: begin
				u_q    <= num_mag;
				v_q    <= den_mag;
				fn_q   <= num_q;
				fd_q   <= den_q;
				flag_q <= (den_q == '0);
			end
			CMD_GCD_STEP: begin
				// Binary GCD: strip shared twos, strip lone twos, subtract odd pairs.
				priority if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			CMD_GCD_FINISH: begin
				g_q   <= v_q << k_q;
				quo_q <= num_mag;
				rem_q <= '0;
			end
			CMD_DIV_STEP: begin
				// Restoring division, one quotient bit per cycle.
				if (!div_trial[NW]) begin
					rem_q <= div_trial[NW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[NW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			CMD_NUM_STORE: begin
				fn_q  <= num_q[NW-1] ? (NW'(0) - quo_q) : quo_q;
				quo_q <= den_mag;
				rem_q <= '0;
			end
			CMD_DEN_STORE: begin
				fd_q <= den_q[NW-1] ? (NW'(0) - quo_q) : quo_q;
			end
			CMD_OUT_LOAD: begin
				res_num  <= fn_ext[NUM_OUT_W-1:0];
				res_den  <= fd_ext[DEN_OUT_W-1:0];
				zero_den <= flag_q;
			end
			default: ;
		endcase
	end

	// Result fields take the low bits of the sign-extended final values.
	assign fn_ext    = 64'($signed(fn_q));
	assign fd_ext    = 64'($signed(fd_q));
	assign out_valid = out_valid_q;

	// The GCD operand v never reaches zero while the search runs.
	`FAU_ASSERT_NOW(a_gcd_v_nonzero, ctl.cmd == CMD_GCD_STEP, v_q != '0)
	// The divisor handed to the divider is never zero.
	`FAU_ASSERT_NEXT(a_div_g_nonzero, ctl.cmd == CMD_GCD_FINISH, g_q != '0)
	// The partial remainder stays below the divisor on every step.
	`FAU_ASSERT_NOW(a_div_rem_below, ctl.cmd == CMD_DIV_STEP, rem_q < g_q)
	// A flagged result always carries a zero denominator.
	`FAU_ASSERT_NOW(a_flag_den_zero, out_valid_q && zero_den, res_den == '0)

endmodule

`default_nettype wire

@@ sv/fraction_arithmetic_unit.sv @@
// Sequence: accept, multiply, check, then binary GCD steps until the search ends,
// then two restoring divisions, numerator and denominator, each followed by a store, then output.
// A zero denominator skips the GCD and both divisions. One transaction at a time.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (arst_n low) returns the controller to idle and clears the output valid.
`default_nettype none

module fraction_arithmetic_unit
	import fau_pkg::*;
#(
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      op,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [NUM_OUT_W-1:0]          res_num,
	output logic signed [DEN_OUT_W-1:0]          res_den,
	output logic                                 zero_den
);

	ctl_t  ctl;
	stat_t stat;

	// Sequencer.
	fau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Arithmetic and output register.
	fau_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.ctl       (ctl),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_num   (res_num),
		.res_den   (res_den),
		.zero_den  (zero_den)
	);

endmodule

`default_nettype wire
